### src/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// Shared types, widths and constants of the junction corner speed block.
// ----------------------------------------------------------------------------
package jcs_pkg;

  // Axis count limits and default
  localparam int unsigned MAX_AXES       = 6;
  localparam int unsigned AXIS_COUNT_DEF = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DEV_W      = 24;
  localparam int unsigned ACC_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEV_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 3'd6;

  localparam logic [DEV_W-1:0] DEV_RESET   = 24'd3277;
  localparam logic [ACC_W-1:0] ACCEL_RESET = 32'd100000;

  // Corner kinds
  localparam logic [1:0] KIND_CORNER   = 2'd0;
  localparam logic [1:0] KIND_STRAIGHT = 2'd1;
  localparam logic [1:0] KIND_REVERSAL = 2'd2;

  // Datapath widths
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned PROD_W  = 32;  // unit x unit, signed
  localparam int unsigned COS_W   = 35;  // sum of products, signed Q4.30
  localparam int unsigned P_W     = 25;  // scaled deviation, Q.16
  localparam int unsigned SQ_W    = 50;
  localparam int unsigned SQS_W   = 53;  // sum of squares over all axes
  localparam int unsigned RAD1_W  = 60;  // radicand of the first root stage
  localparam int unsigned ROOT1_W = RAD1_W / 2;
  localparam int unsigned DELTA_W = 27;
  localparam int unsigned S_W     = 30;
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned NUM_W   = DELTA_W + S_W;
  localparam int unsigned QUO_W   = 36;  // radius, Q.16
  localparam int unsigned RAD2_W  = 64;
  localparam int unsigned ROOT2_W = RAD2_W / 2;
  localparam int unsigned SPEED_W = 24;

  localparam logic signed [COS_W-1:0] COS_LIMIT = 35'sd1063004406;
  localparam logic [67:0]             V2_LIMIT  = 68'd6553600000000000000;
  localparam logic [SPEED_W-1:0]      SPEED_CAP = 24'd10000000;

  // Item payloads
  typedef struct packed {
    logic signed [UNIT_W-1:0] prev_unit_x;
    logic signed [UNIT_W-1:0] prev_unit_y;
    logic signed [UNIT_W-1:0] prev_unit_z;
    logic signed [UNIT_W-1:0] prev_unit_a;
    logic signed [UNIT_W-1:0] prev_unit_b;
    logic signed [UNIT_W-1:0] prev_unit_c;
    logic signed [UNIT_W-1:0] next_unit_x;
    logic signed [UNIT_W-1:0] next_unit_y;
    logic signed [UNIT_W-1:0] next_unit_z;
    logic signed [UNIT_W-1:0] next_unit_a;
    logic signed [UNIT_W-1:0] next_unit_b;
    logic signed [UNIT_W-1:0] next_unit_c;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] corner_speed;
    logic [1:0]         corner_kind;
  } out_item_t;

endpackage

### src/jcs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// jcs_sqrt_pipe
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module jcs_sqrt_pipe #(
  parameter int unsigned IN_W   = 60,
  parameter int unsigned SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [IN_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [IN_W/2-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned ROOT_W = IN_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic              vld_q  [ROOT_W];
  logic [IN_W-1:0]   x_q    [ROOT_W];
  logic [ROOT_W-1:0] r_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_in;
    logic [IN_W-1:0]   x_in;
    logic [ROOT_W-1:0] r_in;
    logic [REM_W-1:0]  rem_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic [ROOT_W-1:0] r_d;
    logic [REM_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = rad_i;
      assign r_in    = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign r_in    = r_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next bit pair and try the subtraction
    always_comb begin
      t     = {rem_in, x_in[IN_W-1 -: 2]};
      trial = (REM_W+2)'({r_in, 2'b01});
      if (t >= trial) begin
        rem_d = REM_W'(t - trial);
        r_d   = {r_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d = REM_W'(t);
        r_d   = {r_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_in << 2;
        r_q[k]    <= r_d;
        rem_q[k]  <= rem_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = r_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

### src/jcs_div_pipe.sv
// ----------------------------------------------------------------------------
// jcs_div_pipe
// Pipelined restoring divider, one quotient bit per register stage. The
// quotient must fit in QUO_W bits, i.e. num >> QUO_W stays below den.
// ----------------------------------------------------------------------------
module jcs_div_pipe #(
  parameter int unsigned NUM_W  = 57,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned QUO_W  = 36,
  parameter int unsigned SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [QUO_W];
  logic [QUO_W-1:0]  x_q    [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              vld_in;
    logic [QUO_W-1:0]  x_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    t;
    logic              qbit;
    logic [DEN_W-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign x_in    = num_i[QUO_W-1:0];
      assign rem_in  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next numerator bit and subtract where it fits
    always_comb begin
      t = {rem_in, x_in[QUO_W-1]};
      if (t >= {1'b0, den_in}) begin
        qbit  = 1'b1;
        rem_d = DEN_W'(t - {1'b0, den_in});
      end else begin
        qbit  = 1'b0;
        rem_d = DEN_W'(t);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= {x_in[QUO_W-2:0], qbit};
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign quo_o  = x_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

### src/junction_corner_speed.sv
// ----------------------------------------------------------------------------
// junction_corner_speed
// Highest speed through the corner between two moves, from their unit
// vectors and the per-axis junction deviations.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    in_item_i  (jcs_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i  out_item_o (jcs_pkg::out_item_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled. The pipeline has 106
// register stages: 3 product/sum stages, a 30-stage root, 2 stages to the
// numerator, a 36-stage divider, 2 multiply stages, a 32-stage root and the
// output register. All stages advance together; they hold only while the
// output register is full and not taken. Reset clears the valid bits and
// loads the register reset values.
// ----------------------------------------------------------------------------
module junction_corner_speed #(
  parameter int unsigned AXIS_COUNT = jcs_pkg::AXIS_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  jcs_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output jcs_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [jcs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [jcs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import jcs_pkg::*;

  logic adv;

  // Configuration registers
  logic [DEV_W-1:0] dev_q [AXIS_COUNT];
  logic [ACC_W-1:0] accel_q;

  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_dev
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dev_q[i] <= DEV_RESET;
      end else if (cfg_we_i && cfg_idx_i == REG_DEV_X + CFG_IDX_W'(i)) begin
        dev_q[i] <= cfg_data_i[DEV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACCEL_RESET;
    end else if (cfg_we_i && cfg_idx_i == REG_ACCEL) begin
      accel_q <= cfg_data_i[ACC_W-1:0];
    end
  end

  // Unpack the item into axis vectors
  logic signed [UNIT_W-1:0] pv [MAX_AXES];
  logic signed [UNIT_W-1:0] nv [MAX_AXES];

  always_comb begin
    pv[0] = in_item_i.prev_unit_x;
    pv[1] = in_item_i.prev_unit_y;
    pv[2] = in_item_i.prev_unit_z;
    pv[3] = in_item_i.prev_unit_a;
    pv[4] = in_item_i.prev_unit_b;
    pv[5] = in_item_i.prev_unit_c;
    nv[0] = in_item_i.next_unit_x;
    nv[1] = in_item_i.next_unit_y;
    nv[2] = in_item_i.next_unit_z;
    nv[3] = in_item_i.next_unit_a;
    nv[4] = in_item_i.next_unit_b;
    nv[5] = in_item_i.next_unit_c;
  end

  // Stage 1: dot products and scaled deviations
  logic                     v1_q;
  logic signed [PROD_W-1:0] prod_q [AXIS_COUNT];
  logic [P_W-1:0]           pp_q   [AXIS_COUNT];
  logic [P_W-1:0]           pn_q   [AXIS_COUNT];

  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_s1
    logic [UNIT_W-1:0]       mag_p;
    logic [UNIT_W-1:0]       mag_n;
    logic [UNIT_W+DEV_W-1:0] sc_p;
    logic [UNIT_W+DEV_W-1:0] sc_n;

    assign mag_p = pv[i][UNIT_W-1] ? (~pv[i] + 1'b1) : pv[i];
    assign mag_n = nv[i][UNIT_W-1] ? (~nv[i] + 1'b1) : nv[i];
    assign sc_p  = (UNIT_W+DEV_W)'(mag_p) * (UNIT_W+DEV_W)'(dev_q[i]);
    assign sc_n  = (UNIT_W+DEV_W)'(mag_n) * (UNIT_W+DEV_W)'(dev_q[i]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[i] <= PROD_W'(pv[i]) * PROD_W'(nv[i]);
        pp_q[i]   <= sc_p[UNIT_W+DEV_W-1:15];
        pn_q[i]   <= sc_n[UNIT_W+DEV_W-1:15];
      end
    end
  end

  // Stage 2: cosine and squares
  logic                    v2_q;
  logic signed [COS_W-1:0] cos_q;
  logic [SQ_W-1:0]         sqp_q [AXIS_COUNT];
  logic [SQ_W-1:0]         sqn_q [AXIS_COUNT];
  logic signed [COS_W-1:0] cos_d;

  always_comb begin
    cos_d = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      cos_d = cos_d - COS_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q <= cos_d;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        sqp_q[i] <= SQ_W'(pp_q[i]) * SQ_W'(pp_q[i]);
        sqn_q[i] <= SQ_W'(pn_q[i]) * SQ_W'(pn_q[i]);
      end
    end
  end

  // Stage 3: classify, half-angle argument, sums of squares
  logic                    v3_q;
  logic [1:0]              kind3_q;
  logic [S_W-1:0]          h_q;
  logic [SQS_W-1:0]        sump_q;
  logic [SQS_W-1:0]        sumn_q;
  logic [1:0]              kind3_d;
  logic signed [COS_W:0]   hw;
  logic [SQS_W-1:0]        sump_d;
  logic [SQS_W-1:0]        sumn_d;

  always_comb begin
    priority if (cos_q <= -COS_LIMIT) begin
      kind3_d = KIND_STRAIGHT;
    end else if (cos_q >= COS_LIMIT) begin
      kind3_d = KIND_REVERSAL;
    end else begin
      kind3_d = KIND_CORNER;
    end
    hw     = (COS_W+1)'(36'sd1073741824) - (COS_W+1)'(cos_q);
    sump_d = '0;
    sumn_d = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      sump_d = sump_d + SQS_W'(sqp_q[i]);
      sumn_d = sumn_d + SQS_W'(sqn_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind3_q <= kind3_d;
      h_q     <= hw[S_W:1];
      sump_q  <= sump_d;
      sumn_q  <= sumn_d;
    end
  end

  // Roots of the fused deviations and of the half-angle term
  logic               v4;
  logic [1:0]         kind4;
  logic [ROOT1_W-1:0] rootp;
  logic [ROOT1_W-1:0] rootn;
  logic [ROOT1_W-1:0] root_s;
  logic               unused_side_p;
  logic               unused_side_n;

  jcs_sqrt_pipe #(.IN_W(RAD1_W), .SIDE_W(2)) u_sqrt_s (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(v3_q),
    .rad_i ({h_q, 30'd0}),
    .side_i(kind3_q),
    .vld_o (v4), .root_o(root_s), .side_o(kind4)
  );

  jcs_sqrt_pipe #(.IN_W(RAD1_W), .SIDE_W(1)) u_sqrt_p (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(v3_q),
    .rad_i (RAD1_W'(sump_q)),
    .side_i(1'b0),
    .vld_o (), .root_o(rootp), .side_o(unused_side_p)
  );

  jcs_sqrt_pipe #(.IN_W(RAD1_W), .SIDE_W(1)) u_sqrt_n (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(v3_q),
    .rad_i (RAD1_W'(sumn_q)),
    .side_i(1'b0),
    .vld_o (), .root_o(rootn), .side_o(unused_side_n)
  );

  // Stage 5: deviation delta and divisor
  logic               v5_q;
  logic [1:0]         kind5_q;
  logic [DELTA_W-1:0] delta_q;
  logic [S_W-1:0]     s5_q;
  logic [DEN_W-1:0]   den5_q;
  logic [DELTA_W:0]   dsum;

  assign dsum = (DELTA_W+1)'(rootp[DELTA_W-1:0]) + (DELTA_W+1)'(rootn[DELTA_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind5_q <= kind4;
      delta_q <= dsum[DELTA_W:1];
      s5_q    <= root_s;
      den5_q  <= {1'b1, 30'd0} - DEN_W'(root_s);
    end
  end

  // Stage 6: radius numerator
  logic             v6_q;
  logic [1:0]       kind6_q;
  logic [NUM_W-1:0] num6_q;
  logic [DEN_W-1:0] den6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind6_q <= kind5_q;
      num6_q  <= NUM_W'(delta_q) * NUM_W'(s5_q);
      den6_q  <= den5_q;
    end
  end

  // Radius divide
  logic             vd;
  logic [1:0]       kindd;
  logic [QUO_W-1:0] radius;

  jcs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W), .SIDE_W(2)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(v6_q),
    .num_i (num6_q), .den_i(den6_q), .side_i(kind6_q),
    .vld_o (vd), .quo_o(radius), .side_o(kindd)
  );

  // Stage 7: radius times acceleration, as two partial products
  logic        v7_q;
  logic [1:0]  kind7_q;
  logic [63:0] rlo_q;
  logic [35:0] rhi_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind7_q <= kindd;
      rlo_q   <= 64'(radius[31:0]) * 64'(accel_q);
      rhi_q   <= 36'(radius[QUO_W-1:32]) * 36'(accel_q);
    end
  end

  // Stage 8: combine and test for saturation
  logic        v8_q;
  logic [1:0]  kind8_q;
  logic        sat8_q;
  logic [62:0] rprod_q;
  logic [67:0] full;

  assign full = {rhi_q, 32'd0} + 68'(rlo_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind8_q <= kind7_q;
      sat8_q  <= full > V2_LIMIT;
      rprod_q <= full[62:0];
    end
  end

  // Speed root
  logic               vr;
  logic [2:0]         sider;
  logic [ROOT2_W-1:0] root_v;

  jcs_sqrt_pipe #(.IN_W(RAD2_W), .SIDE_W(3)) u_sqrt_v (
    .clk_i, .rst_ni, .en_i(adv), .vld_i(v8_q),
    .rad_i (RAD2_W'(rprod_q)),
    .side_i({kind8_q, sat8_q}),
    .vld_o (vr), .root_o(root_v), .side_o(sider)
  );

  // Valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v5_q <= v4;
      v6_q <= v5_q;
      v7_q <= vd;
      v8_q <= v7_q;
    end
  end

  // Output register: pick the special cases, cap the speed
  logic               out_vld_q;
  out_item_t          out_q;
  out_item_t          out_d;
  logic [SPEED_W-1:0] vspeed;

  always_comb begin
    vspeed = root_v[ROOT2_W-1:8];
    out_d.corner_kind = sider[2:1];
    unique case (sider[2:1])
      KIND_STRAIGHT: out_d.corner_speed = SPEED_CAP;
      KIND_REVERSAL: out_d.corner_speed = '0;
      default: begin
        if (sider[0] || vspeed > SPEED_CAP) begin
          out_d.corner_speed = SPEED_CAP;
        end else begin
          out_d.corner_speed = vspeed;
        end
      end
    endcase
  end

  assign adv = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = adv;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  // Checks
  a_rev_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.corner_kind == KIND_REVERSAL |-> out_q.corner_speed == '0)
    else $error("reversal with non-zero speed");

  a_straight_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.corner_kind == KIND_STRAIGHT |-> out_q.corner_speed == SPEED_CAP)
    else $error("straight line below speed cap");

  a_speed_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.corner_speed <= SPEED_CAP)
    else $error("speed above cap");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_vld_q && !out_ready_i)
    else $error("input held without output back-pressure");

endmodule

### tb/tb_junction_corner_speed.sv
// ----------------------------------------------------------------------------
// tb_junction_corner_speed
// Self-checking bench: drives corners through the block in several register
// settings with random idling on both sides and compares each result with a
// bit-exact fixed-point prediction, in order.
// ----------------------------------------------------------------------------
module tb_junction_corner_speed;
  timeunit 1ns;
  timeprecision 1ps;
  import jcs_pkg::*;

  localparam int unsigned PIPE_DRAIN = 130;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Expected corners and the register copy they are computed from
  class corner_board;
    logic [DEV_W-1:0] dev[MAX_AXES];
    logic [ACC_W-1:0] accel;
    out_item_t        pending[$];
    int unsigned      errors;

    function void load_defaults();
      foreach (dev[i]) dev[i] = DEV_RESET;
      accel = ACCEL_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ACCEL) accel = data;
      else if (idx < REG_ACCEL) dev[idx - REG_DEV_X] = data[DEV_W-1:0];
    endfunction

    static function longint unsigned root64(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Deviation of one vector, fused over the axes
    function longint unsigned fuse(longint signed u[MAX_AXES]);
      longint unsigned sum, mag, p;
      sum = 0;
      for (int i = 0; i < MAX_AXES; i++) begin
        mag = (u[i] < 0) ? -u[i] : u[i];
        p = (mag * dev[i]) >> 15;
        sum += p * p;
      end
      return root64(sum);
    endfunction

    function out_item_t corner_of(in_item_t it);
      longint signed   pv[MAX_AXES], nv[MAX_AXES];
      longint signed   cosq;
      longint unsigned delta, h, s, radius, v;
      out_item_t       r;
      pv[0] = it.prev_unit_x; pv[1] = it.prev_unit_y; pv[2] = it.prev_unit_z;
      pv[3] = it.prev_unit_a; pv[4] = it.prev_unit_b; pv[5] = it.prev_unit_c;
      nv[0] = it.next_unit_x; nv[1] = it.next_unit_y; nv[2] = it.next_unit_z;
      nv[3] = it.next_unit_a; nv[4] = it.next_unit_b; nv[5] = it.next_unit_c;
      cosq = 0;
      for (int i = 0; i < MAX_AXES; i++) cosq -= pv[i] * nv[i];
      if (cosq <= -longint'(COS_LIMIT)) begin
        r.corner_speed = SPEED_CAP;
        r.corner_kind  = KIND_STRAIGHT;
        return r;
      end
      if (cosq >= longint'(COS_LIMIT)) begin
        r.corner_speed = '0;
        r.corner_kind  = KIND_REVERSAL;
        return r;
      end
      delta  = (fuse(pv) + fuse(nv)) >> 1;
      h      = longint'(64'd1 << 30) - cosq;
      h      = h >> 1;
      s      = root64(h << 30);
      radius = (delta * s) / ((64'd1 << 30) - s);
      if (accel != 0 && radius > 64'd6553600000000000000 / accel) begin
        v = SPEED_CAP;
      end else begin
        v = root64(radius * accel) >> 8;
        if (v > SPEED_CAP) v = SPEED_CAP;
      end
      r.corner_speed = v[SPEED_W-1:0];
      r.corner_kind  = KIND_CORNER;
      return r;
    endfunction

    function void note_corner(in_item_t it);
      pending.push_back(corner_of(it));
    endfunction

    task report(string what);
      $display("ERROR %s", what);
      errors++;
    endtask

    task check_corner(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item speed=%0d kind=%0d",
                         got.corner_speed, got.corner_kind));
        return;
      end
      want = pending.pop_front();
      if (got.corner_speed !== want.corner_speed)
        report($sformatf("corner_speed got %0d want %0d",
                         got.corner_speed, want.corner_speed));
      if (got.corner_kind !== want.corner_kind)
        report($sformatf("corner_kind got %0d want %0d",
                         got.corner_kind, want.corner_kind));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  corner_board board = new();
  bit          idle_on = 1'b1;
  bit          holdoff_req = 1'b0;
  int unsigned cycles = 0;

  junction_corner_speed dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both handshakes and the run limit
  always @(posedge clk_i) begin
    cycles++;
    if (in_valid_i && in_ready_o) board.note_corner(in_item_i);
    if (out_valid_o && out_ready_i) board.check_corner(out_item_o);
    if (cycles > CYCLE_CAP) begin
      $display("junction_corner_speed: mismatch");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req && stall == 0) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        holdoff_req = 1'b0;
      end
      if (stall > 0) stall--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 10);
      out_ready_i = (stall == 0);
    end
  end

  task cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one item and hold it until taken; called at a falling edge
  task send(in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid_i = 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  function automatic in_item_t make_corner(int mode);
    in_item_t it;
    logic [15:0] v[12];
    int unsigned span;
    span = (mode == 0) ? 65535 : $urandom_range(200, 20000);
    foreach (v[i]) begin
      if (mode == 0) v[i] = $urandom();
      else v[i] = 16'($signed($urandom_range(0, 2 * span)) - int'(span));
    end
    // sometimes make the next move nearly the same or exactly opposed
    if (mode == 2) begin
      for (int i = 0; i < 6; i++) v[6 + i] = v[i] + 16'($urandom_range(0, 3)) - 16'd1;
    end
    if (mode == 3) for (int i = 0; i < 6; i++) v[6 + i] = -v[i];
    it = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
    return it;
  endfunction

  task random_phase(int unsigned count);
    int m;
    for (int unsigned n = 0; n < count; n++) begin
      m = $urandom_range(0, 9);
      send(make_corner(m < 2 ? 0 : (m < 7 ? 1 : (m < 9 ? 2 : 3))));
    end
  endtask

  function automatic in_item_t pair(logic signed [15:0] p[6], logic signed [15:0] q[6]);
    return {p[0], p[1], p[2], p[3], p[4], p[5], q[0], q[1], q[2], q[3], q[4], q[5]};
  endfunction

  initial begin : stimulus
    logic signed [15:0] ux[6], uy[6], nx[6], zr[6], mx[6], mn[6], dg[6], th[6];
    board.load_defaults();
    ux = '{32767, 0, 0, 0, 0, 0};
    uy = '{0, 32767, 0, 0, 0, 0};
    nx = '{-32768, 0, 0, 0, 0, 0};
    zr = '{0, 0, 0, 0, 0, 0};
    mx = '{32767, 32767, 32767, 32767, 32767, 32767};
    mn = '{-32768, -32768, -32768, -32768, -32768, -32768};
    dg = '{23170, 0, 0, 0, 0, 23170};
    th = '{32440, 0, 0, 0, 4600, 0};
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners at reset values
    send(pair(ux, ux));  // straight line
    send(pair(ux, nx));  // reversal, minus one counts as -1.0
    send(pair(ux, uy));  // right angle
    send(pair(zr, zr));  // null vectors
    send(pair(mx, mx));
    send(pair(mn, mn));
    send(pair(mx, mn));
    send(pair(dg, ux));
    send(pair(ux, dg));
    send(pair(th, ux));  // near the straight threshold
    send(pair(nx, th));  // near the reversal threshold
    send(pair(zr, mn));
    send(pair(dg, uy));
    random_phase(PHASE_ITEMS);
    holdoff_req = 1'b1;
    random_phase(60);
    drain();

    // Largest deviations and acceleration: saturation
    for (int i = 0; i < 6; i++) cfg_write(CFG_IDX_W'(REG_DEV_X + i), 32'hFFFFFF);
    cfg_write(REG_ACCEL, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE, 32'h1234);  // index out of range, ignored
    send(pair(ux, uy));
    send(pair(mx, dg));
    random_phase(PHASE_ITEMS);
    drain();

    // No acceleration
    cfg_write(REG_ACCEL, 32'd0);
    send(pair(ux, uy));
    random_phase(PHASE_ITEMS - 60);
    drain();

    // No deviation, some acceleration
    for (int i = 0; i < 6; i++) cfg_write(CFG_IDX_W'(REG_DEV_X + i), 32'd0);
    cfg_write(REG_ACCEL, 32'd1);
    random_phase(PHASE_ITEMS - 60);
    drain();

    // Random settings, no idling at the end
    for (int i = 0; i < 6; i++) begin
      cfg_write(CFG_IDX_W'(REG_DEV_X + i), $urandom_range(0, 24'hFFFFFF));
    end
    cfg_write(REG_ACCEL, $urandom());
    random_phase(PHASE_ITEMS / 2);
    drain();
    idle_on = 1'b0;
    cfg_write(CFG_IDX_W'(REG_DEV_X + 2), $urandom_range(0, 4000));
    cfg_write(REG_ACCEL, $urandom_range(1000, 5000000));
    random_phase(PHASE_ITEMS / 2);
    drain();

    if (board.errors == 0) begin
      $display("junction_corner_speed: match");
    end else begin
      $display("junction_corner_speed: mismatch");
    end
    $finish;
  end
endmodule
